// ===== rtl/bpa_pkg.sv =====
// Shared constants, types and helper functions of the bitmap page allocator.
package bpa_pkg;

  localparam int unsigned PAGE_BYTES     = 4096;
  localparam int unsigned PAGE_SHIFT     = $clog2(PAGE_BYTES);
  localparam int unsigned RESERVED_PAGES = 256;
  localparam int unsigned MAP_BYTES_DEF  = 4096;

  localparam int unsigned RAM_KB_W = 22;
  localparam logic [RAM_KB_W-1:0] RAM_KB_RST = 22'd131072;

  localparam int unsigned PG_W  = 33 - PAGE_SHIFT;
  localparam int unsigned WD_W  = 64;
  localparam int unsigned WI_W  = PG_W - 6;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_FREE,
    K_IGNORE
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [PG_W-1:0] need;
    logic [PG_W-1:0] ps;
    logic [PG_W-1:0] pe;
  } cmd_t;

  function automatic logic [WD_W-1:0] lowmask(input logic [6:0] n);
    logic [WD_W-1:0] m;
    if (n >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << n) - 64'd1;
    end
    return m;
  endfunction

  function automatic logic [6:0] clip_off(input logic [PG_W-1:0] page,
                                          input logic [PG_W-1:0] base);
    logic [PG_W-1:0] d;
    logic [6:0] r;
    d = page - base;
    if (page <= base) begin
      r = 7'd0;
    end else if (d >= PG_W'(64)) begin
      r = 7'd64;
    end else begin
      r = d[6:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bpa_front.sv =====
// Front stage: accepts an item, rounds sizes to pages and classifies the request.
module bpa_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  logic                      in_op,
  input  logic [31:0]               in_size_bytes,
  input  logic [31:0]               in_address,
  input  logic [bpa_pkg::PG_W-1:0]  tracked,
  input  logic                      q_full,
  output logic                      ready,
  output logic                      push,
  output bpa_pkg::cmd_t             push_cmd
);

  logic          vld_r, vld_nxt;
  bpa_pkg::cmd_t cmd_r, cmd_nxt;

  logic [32:0]               sz_up;
  logic [bpa_pkg::PG_W-1:0]  cnt;
  logic [bpa_pkg::PG_W-1:0]  ps;
  logic [bpa_pkg::PG_W:0]    end_sum;

  assign sz_up   = {1'b0, in_size_bytes} + 33'(bpa_pkg::PAGE_BYTES - 1);
  assign cnt     = sz_up[32:bpa_pkg::PAGE_SHIFT];
  assign ps      = {1'b0, in_address[31:bpa_pkg::PAGE_SHIFT]};
  assign end_sum = {1'b0, ps} + {1'b0, cnt};

  always_comb begin
    cmd_nxt = cmd_r;
    if (acc) begin
      cmd_nxt.need = (cnt == '0) ? bpa_pkg::PG_W'(1) : cnt;
      cmd_nxt.ps   = ps;
      cmd_nxt.pe   = (end_sum > {1'b0, tracked}) ? tracked : end_sum[bpa_pkg::PG_W-1:0];
      if (in_op == bpa_pkg::OP_ALLOC) begin
        cmd_nxt.kind = bpa_pkg::K_ALLOC;
      end else if (in_address == 32'd0) begin
        cmd_nxt.kind = bpa_pkg::K_IGNORE;
      end else begin
        cmd_nxt.kind = bpa_pkg::K_FREE;
      end
    end
  end

  assign ready    = !vld_r || !q_full;
  assign push     = vld_r && !q_full;
  assign push_cmd = cmd_r;

  always_comb begin
    vld_nxt = vld_r;
    if (acc) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

// ===== rtl/bpa_queue.sv =====
// Short command queue between the front stage and the map engine.
module bpa_queue #(
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bpa_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          vld,
  output bpa_pkg::cmd_t head
);

  bpa_pkg::cmd_t       ent_r [DEPTH];
  logic [PW-1:0]       wp_r, rp_r;
  logic [PW:0]         cnt_r;

  assign full = (cnt_r == (PW+1)'(DEPTH));
  assign vld  = (cnt_r != '0);
  assign head = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/bpa_back.sv =====
// Map engine: clears the map, runs first-fit scans and sets or clears page ranges.
module bpa_back #(
  parameter int unsigned MAP_BYTES = bpa_pkg::MAP_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      init,
  input  logic [bpa_pkg::PG_W-1:0]  tracked,
  input  logic                      q_vld,
  input  bpa_pkg::cmd_t             q_cmd,
  output logic                      q_pop,
  output logic                      clearing,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [31:0]               out_block_address
);

  localparam int unsigned WORDS = (MAP_BYTES + 7) / 8;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PG_W  = bpa_pkg::PG_W;
  localparam int unsigned WI_W  = bpa_pkg::WI_W;
  localparam logic [WI_W-1:0] LAST_W = WI_W'(WORDS - 1);

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_SCAN,
    B_MWR
  } bstate_t;

  bstate_t          state_r, state_nxt;
  logic [WI_W-1:0]  w_r, w_nxt;
  bpa_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [PG_W-1:0]  run_in_r, run_in_nxt;
  logic [PG_W-1:0]  run_start_r, run_start_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic             ov_r, ov_nxt;
  logic [1:0]       os_r, os_nxt;
  logic [31:0]      oa_r, oa_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_wa, ram_ra;
  logic [63:0]      ram_wd, rdata;

  logic [PG_W-1:0]  base;
  logic [PG_W:0]    nw;
  logic             last_scan;
  logic [63:0]      blocked, pfx, hit;
  logic             hit_found;
  logic [5:0]       hit_idx, hb;
  logic [PG_W-1:0]  hit_start, rem, limit;
  logic [63:0]      mod_mask, clr_pat;
  logic [WI_W-1:0]  we_word;
  logic [PG_W-1:0]  pe_m1;

  bpa_ram #(.WIDTH(64), .DEPTH(WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (rdata)
  );

  assign base      = {w_r, 6'b0};
  assign nw        = ({1'b0, tracked} + (PG_W+1)'(63)) >> 6;
  assign last_scan = (({1'b0, w_r} + (WI_W+1)'(1)) >= nw[WI_W:0]);
  assign rem       = cmd_r.need - run_in_r;
  assign limit     = (tracked < PG_W'(bpa_pkg::RESERVED_PAGES)) ? tracked
                     : PG_W'(bpa_pkg::RESERVED_PAGES);
  assign clr_pat   = bpa_pkg::lowmask(bpa_pkg::clip_off(limit, base));
  assign mod_mask  = bpa_pkg::lowmask(bpa_pkg::clip_off(cmd_r.pe, base))
                     & ~bpa_pkg::lowmask(bpa_pkg::clip_off(cmd_r.ps, base));
  assign pe_m1     = cmd_r.pe - PG_W'(1);
  assign we_word   = pe_m1[PG_W-1:6];

  always_comb begin
    logic [63:0]     lm;
    logic [63:0]     bz;
    logic [6:0]      sh;
    logic            need_small;
    need_small = (cmd_r.need <= PG_W'(64));
    for (int i = 0; i < 64; i++) begin
      blocked[i] = rdata[i] || !((base + PG_W'(i)) < tracked);
    end
    for (int i = 0; i < 64; i++) begin
      lm     = bpa_pkg::lowmask(7'(i + 1));
      bz     = blocked & lm;
      pfx[i] = (bz == '0);
      sh     = 7'(i + 1) - cmd_r.need[6:0];
      hit[i] = (pfx[i] && (PG_W'(i + 1) >= rem))
               || (need_small && (PG_W'(i + 1) >= cmd_r.need) && ((bz >> sh) == '0));
    end
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = 63; i >= 0; i--) begin
      if (hit[i]) begin
        hit_found = 1'b1;
        hit_idx   = 6'(i);
      end
    end
    hb = '0;
    for (int i = 0; i < 64; i++) begin
      if (blocked[i]) begin
        hb = 6'(i);
      end
    end
  end

  assign hit_start = (pfx[hit_idx] && (run_in_r != '0)) ? run_start_r
                     : base + PG_W'(hit_idx) + PG_W'(1) - cmd_r.need;

  always_comb begin
    logic [PG_W+11:0] sa;
    state_nxt     = state_r;
    w_nxt         = w_r;
    cmd_nxt       = cmd_r;
    run_in_nxt    = run_in_r;
    run_start_nxt = run_start_r;
    addr_nxt      = addr_r;
    ov_nxt        = 1'b0;
    os_nxt        = os_r;
    oa_nxt        = oa_r;
    ram_we        = 1'b0;
    ram_wa        = w_r[AW-1:0];
    ram_wd        = '0;
    ram_ra        = w_r[AW-1:0];
    q_pop         = 1'b0;
    sa            = {hit_start, 12'b0} >> (12 - bpa_pkg::PAGE_SHIFT);
    case (state_r)
      B_CLEAR: begin
        ram_we = 1'b1;
        ram_wd = clr_pat;
        if (w_r == LAST_W) begin
          state_nxt = B_IDLE;
          w_nxt     = '0;
        end else begin
          w_nxt = w_r + WI_W'(1);
        end
      end
      B_IDLE: begin
        if (q_vld && !init) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          case (q_cmd.kind)
            bpa_pkg::K_ALLOC: begin
              if (tracked == '0) begin
                ov_nxt = 1'b1;
                os_nxt = bpa_pkg::ST_NOSPACE;
                oa_nxt = '0;
              end else begin
                w_nxt      = '0;
                ram_ra     = '0;
                run_in_nxt = '0;
                state_nxt  = B_SCAN;
              end
            end
            bpa_pkg::K_FREE: begin
              if (q_cmd.ps >= q_cmd.pe) begin
                ov_nxt = 1'b1;
                os_nxt = bpa_pkg::ST_FREED;
                oa_nxt = '0;
              end else begin
                w_nxt     = q_cmd.ps[PG_W-1:6];
                ram_ra    = q_cmd.ps[AW+5:6];
                state_nxt = B_MWR;
              end
            end
            default: begin
              ov_nxt = 1'b1;
              os_nxt = bpa_pkg::ST_IGNORED;
              oa_nxt = '0;
            end
          endcase
        end
      end
      B_SCAN: begin
        if (hit_found) begin
          cmd_nxt.ps = hit_start;
          cmd_nxt.pe = hit_start + cmd_r.need;
          addr_nxt   = sa[31:0];
          w_nxt      = hit_start[PG_W-1:6];
          ram_ra     = hit_start[AW+5:6];
          state_nxt  = B_MWR;
        end else if (last_scan) begin
          ov_nxt    = 1'b1;
          os_nxt    = bpa_pkg::ST_NOSPACE;
          oa_nxt    = '0;
          state_nxt = B_IDLE;
        end else begin
          if (pfx[63]) begin
            run_in_nxt    = run_in_r + PG_W'(64);
            run_start_nxt = (run_in_r == '0) ? base : run_start_r;
          end else begin
            run_in_nxt    = PG_W'(6'd63 - hb);
            run_start_nxt = base + PG_W'(hb) + PG_W'(1);
          end
          w_nxt  = w_r + WI_W'(1);
          ram_ra = w_nxt[AW-1:0];
        end
      end
      B_MWR: begin
        ram_we = 1'b1;
        ram_wd = (cmd_r.kind == bpa_pkg::K_ALLOC) ? (rdata | mod_mask) : (rdata & ~mod_mask);
        if (w_r == we_word) begin
          ov_nxt    = 1'b1;
          state_nxt = B_IDLE;
          if (cmd_r.kind == bpa_pkg::K_ALLOC) begin
            os_nxt = bpa_pkg::ST_ALLOC;
            oa_nxt = addr_r;
          end else begin
            os_nxt = bpa_pkg::ST_FREED;
            oa_nxt = '0;
          end
        end else begin
          w_nxt  = w_r + WI_W'(1);
          ram_ra = w_nxt[AW-1:0];
        end
      end
      default: begin
        state_nxt = B_CLEAR;
        w_nxt     = '0;
      end
    endcase
    if (init) begin
      state_nxt = B_CLEAR;
      w_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      w_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      w_r     <= w_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r       <= cmd_nxt;
    run_in_r    <= run_in_nxt;
    run_start_r <= run_start_nxt;
    addr_r      <= addr_nxt;
    os_r        <= os_nxt;
    oa_r        <= oa_nxt;
  end

  assign clearing          = (state_r == B_CLEAR);
  assign out_valid         = ov_r;
  assign out_status        = os_r;
  assign out_block_address = oa_r;

endmodule

// ===== rtl/bitmap_page_allocator_core.sv =====
// Top level of the bitmap first-fit page allocator.
// An item is taken on a rising edge with start high and busy low: in_op selects allocate
// or free, in_size_bytes gives the size and in_address the block to free.
// Every item gives exactly one result, shown for one cycle with out_valid high, carrying
// out_status and out_block_address. The receiver cannot stall; results are never held.
// The front stage registers and classifies an item, a two-entry queue passes it to the map
// engine, so up to three more items can wait while the engine works on one.
// The engine keeps the page map in a 64-bit wide RAM, one word read per cycle.
// An allocate scans one word per cycle from word 0 until a run fits, then sets the
// run with one read-modify-write word per cycle; a free clears its page range word by
// word with read-modify-write. After reset, and after each write of cfg_ram_kb, the
// engine rewrites every map word to mark the reserved pages; busy and a low cfg_ready
// show that pass. cfg_ram_kb is written with cfg_valid and cfg_ready both high.
module bitmap_page_allocator_core #(
  parameter int unsigned MAP_BYTES = bpa_pkg::MAP_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [31:0]                   in_size_bytes,
  input  logic [31:0]                   in_address,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [31:0]                   out_block_address,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpa_pkg::RAM_KB_W-1:0]  cfg_ram_kb
);

  localparam int unsigned PG_W = bpa_pkg::PG_W;
  localparam logic [PG_W-1:0] MAP_BITS = PG_W'(MAP_BYTES * 8);

  logic [PG_W-1:0] tracked_r, tracked_nxt;
  logic            cfg_wr, acc, fr_ready, q_full, q_vld, q_pop, push, clearing;
  bpa_pkg::cmd_t   push_cmd, q_head;
  logic [PG_W-1:0] pg_raw;

  function automatic logic [PG_W-1:0] pages_of(input logic [bpa_pkg::RAM_KB_W-1:0] kb);
    logic [31:0] b;
    logic [31:0] p;
    b = {kb, 10'b0};
    p = b >> bpa_pkg::PAGE_SHIFT;
    return (p > 32'(MAP_BITS)) ? MAP_BITS : p[PG_W-1:0];
  endfunction

  assign cfg_ready   = !clearing;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign busy        = !fr_ready || clearing || cfg_valid;
  assign acc         = start && !busy;
  assign pg_raw      = pages_of(cfg_ram_kb);
  assign tracked_nxt = cfg_wr ? pg_raw : tracked_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_r <= pages_of(bpa_pkg::RAM_KB_RST);
    end else begin
      tracked_r <= tracked_nxt;
    end
  end

  bpa_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .in_op         (in_op),
    .in_size_bytes (in_size_bytes),
    .in_address    (in_address),
    .tracked       (tracked_r),
    .q_full        (q_full),
    .ready         (fr_ready),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  bpa_queue #(.DEPTH(2)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .vld      (q_vld),
    .head     (q_head)
  );

  bpa_back #(.MAP_BYTES(MAP_BYTES)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .init              (cfg_wr),
    .tracked           (tracked_r),
    .q_vld             (q_vld),
    .q_cmd             (q_head),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_block_address (out_block_address)
  );

endmodule

// ===== rtl/bpa_checker.sv =====
// Port-level checks of the page allocator and their binding to the top level.
module bpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [31:0] out_block_address
);

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != bpa_pkg::ST_ALLOC) |-> out_block_address == 32'd0)
    else $error("Result address is not zero on a non-allocate status.");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("Block is not rebuilding the map after reset.");

  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> busy && !cfg_ready)
    else $error("Map rebuild did not start after a configuration write.");

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (.*);

// ===== sim/tb_bitmap_page_allocator_core.sv =====
// Testbench for the bitmap page allocator: random and directed items checked against a map model.
module tb_bitmap_page_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAP_PAGES = bpa_pkg::MAP_BYTES_DEF * 8;

  class alloc_scoreboard;
    bit page_used [MAP_PAGES];
    longint unsigned tracked;
    logic [1:0] status_q[$];
    logic [31:0] addr_q[$];
    int errors;
    int checked;

    function void load_map(logic [bpa_pkg::RAM_KB_W-1:0] kb);
      longint unsigned t;
      t = (longint'(kb) * 1024) / bpa_pkg::PAGE_BYTES;
      if (t > MAP_PAGES) t = MAP_PAGES;
      tracked = t;
      for (int p = 0; p < MAP_PAGES; p++) begin
        page_used[p] = (p < bpa_pkg::RESERVED_PAGES) && (p < t);
      end
    endfunction

    function void note_item(logic op, logic [31:0] size, logic [31:0] addr);
      longint unsigned need, run, first, cnt, p0;
      logic [1:0] st;
      logic [31:0] ba;
      st = bpa_pkg::ST_NOSPACE;
      ba = '0;
      if (op == bpa_pkg::OP_ALLOC) begin
        need = (longint'(size) + bpa_pkg::PAGE_BYTES - 1) / bpa_pkg::PAGE_BYTES;
        if (need == 0) need = 1;
        run = 0;
        p0 = 0;
        for (longint unsigned p = 0; p < tracked; p++) begin
          if (!page_used[p]) begin
            if (run == 0) p0 = p;
            run++;
            if (run >= need) begin
              for (longint unsigned q = p0; q < p0 + need; q++) page_used[q] = 1'b1;
              st = bpa_pkg::ST_ALLOC;
              ba = 32'(p0 * bpa_pkg::PAGE_BYTES);
              break;
            end
          end else begin
            run = 0;
          end
        end
      end else if (addr == 0) begin
        st = bpa_pkg::ST_IGNORED;
      end else begin
        first = longint'(addr) / bpa_pkg::PAGE_BYTES;
        cnt = (longint'(size) + bpa_pkg::PAGE_BYTES - 1) / bpa_pkg::PAGE_BYTES;
        for (longint unsigned p = first; p < first + cnt && p < tracked; p++) begin
          page_used[p] = 1'b0;
        end
        st = bpa_pkg::ST_FREED;
      end
      status_q.push_back(st);
      addr_q.push_back(ba);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] ba);
      checked++;
      if (status_q.size() == 0) begin
        report_error("result with no item outstanding");
        return;
      end
      if (st !== status_q[0]) begin
        report_error($sformatf("status %0d, expected %0d", st, status_q[0]));
      end
      if (ba !== addr_q[0]) begin
        report_error($sformatf("block address %h, expected %h", ba, addr_q[0]));
      end
      void'(status_q.pop_front());
      void'(addr_q.pop_front());
    endfunction

    function void report_error(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic [31:0] in_size_bytes = '0;
  logic [31:0] in_address = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [31:0] out_block_address;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bpa_pkg::RAM_KB_W-1:0] cfg_ram_kb = '0;

  alloc_scoreboard sb = new();
  int items_sent;
  int allocs_ok;
  int gap_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_page_allocator_core dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_block_address);
    if (rst_n && out_valid && out_status == bpa_pkg::ST_ALLOC) allocs_ok++;
  end

  task automatic send_item(logic op, logic [31:0] size, logic [31:0] addr);
    int idle;
    if (gap_left == 0) begin
      gap_left = $urandom_range(1, 30);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (idle != 0) begin
        start <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    gap_left--;
    start <= 1'b1;
    in_op <= op;
    in_size_bytes <= size;
    in_address <= addr;
    do @(posedge clk); while (busy);
    sb.note_item(op, size, addr);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic write_ram_kb(logic [bpa_pkg::RAM_KB_W-1:0] kb);
    drain();
    cfg_valid <= 1'b1;
    cfg_ram_kb <= kb;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.load_map(kb);
  endtask

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 8);
      2, 3: return $urandom_range(1, 64 * bpa_pkg::PAGE_BYTES);
      default: return $urandom_range(1, 8 * bpa_pkg::PAGE_BYTES);
    endcase
  endfunction

  task automatic random_phase(int n, longint unsigned span);
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 55) begin
        send_item(bpa_pkg::OP_ALLOC, rand_size(), $urandom());
      end else begin
        case ($urandom_range(0, 5))
          0: a = $urandom();
          1: a = 0;
          2: a = 32'($urandom_range(0, 32'(span)) * bpa_pkg::PAGE_BYTES)
                 + $urandom_range(0, 4095);
          default: a = 32'($urandom_range(0, 32'(span)) * bpa_pkg::PAGE_BYTES);
        endcase
        send_item(bpa_pkg::OP_FREE, rand_size(), a);
      end
    end
  endtask

  initial begin
    sb.load_map(bpa_pkg::RAM_KB_RST);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(bpa_pkg::OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_item(bpa_pkg::OP_ALLOC, 32'd1, 32'd0);
    send_item(bpa_pkg::OP_ALLOC, bpa_pkg::PAGE_BYTES + 1, 32'd0);
    send_item(bpa_pkg::OP_FREE, 32'd4096, 32'd0);
    send_item(bpa_pkg::OP_FREE, 32'd0, 32'h0010_0000);
    send_item(bpa_pkg::OP_FREE, 32'd8192, 32'h0010_0123);
    send_item(bpa_pkg::OP_FREE, 32'd4096, 32'h0000_1000);
    send_item(bpa_pkg::OP_ALLOC, 32'd4096, 32'd0);
    send_item(bpa_pkg::OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_F000);
    send_item(bpa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_item(bpa_pkg::OP_ALLOC, 32'd200 * bpa_pkg::PAGE_BYTES, 32'd0);
    send_item(bpa_pkg::OP_FREE, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(bpa_pkg::OP_ALLOC, 32'd100 * bpa_pkg::PAGE_BYTES, 32'd0);
    random_phase(300, 32768);

    write_ram_kb('0);
    send_item(bpa_pkg::OP_ALLOC, 32'd1, 32'd0);
    send_item(bpa_pkg::OP_FREE, 32'd4096, 32'h0000_2000);
    random_phase(40, 64);

    write_ram_kb(22'd3);
    random_phase(20, 4);
    write_ram_kb(22'd1100);
    random_phase(250, 300);
    write_ram_kb(22'h3F_FFFF);
    random_phase(300, 32768);
    write_ram_kb(22'd4096);
    random_phase(250, 1100);

    drain();
    $display("Sent %0d items over six RAM sizes, %0d results checked, %0d allocations granted.",
             items_sent, sb.checked, allocs_ok);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Timeout with %0d results outstanding.", sb.status_q.size());
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
